### sv/nsr_pkg.sv
// Shared constants and types for the Newton square root core.
// No dependencies; imported by every module of the core.
`default_nettype none

package nsr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_ITER  = 32;
    localparam int VALUE_W   = 32;
    localparam int ROOT_W    = 24;
    localparam int TOL_W     = 31;
    localparam int WORK_W    = VALUE_W + FRAC_BITS;
    localparam int STEP_W    = $clog2(MAX_ITER + 1);
    localparam int DCNT_W    = $clog2(WORK_W + 1);
    localparam int ADDR_W    = 3;
    localparam int APB_DW    = 32;

    localparam logic [ROOT_W-1:0] ROOT_MAX = '1;
    localparam logic [ADDR_W-1:0] ADDR_TOL = '0;
    localparam logic [TOL_W-1:0]  TOL_RST  = TOL_W'(1);

    typedef logic [WORK_W-1:0] t_work;

    typedef struct packed {
        logic  start;
        t_work dividend;
        t_work divisor;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_work quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

### sv/newton_square_root_core.sv
// Q16.16 square root by Newton iteration on a shared bit-serial divider.
// Negative, zero and one operands go straight to the done state; otherwise each Newton
// step runs the divider, then sum, difference, check and restart, for at most 32 steps.
// One item in flight at a time; the serial divider sets the rate. A result waits in the
// output register.
// Reset is synchronous, active low: clears control state, tolerance returns to 1.
`default_nettype none

module newton_square_root_core import nsr_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,   // [31:0] value
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,   // [23:0] root
    output logic [1:0]             m_tuser,   // [0] invalid, [1] capped
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_SUM   = 6'b000100,
        S_DIFF  = 6'b001000,
        S_CHECK = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state              r_state;
    logic [TOL_W-1:0]    r_tol;
    t_work               r_scaled;
    t_work               r_last;
    t_work               r_next;
    t_work               r_diff;
    logic [STEP_W-1:0]   r_steps;
    logic [ROOT_W-1:0]   r_root;
    logic                r_inv;
    logic                r_cap;
    logic                r_m_valid;
    logic [ROOT_W-1:0]   r_m_root;
    logic                r_m_inv;
    logic                r_m_cap;

    t_div_req            div_req;
    t_div_rsp            div_rsp;

    logic [VALUE_W-1:0]  in_val;
    logic                in_acc;
    logic                in_neg;
    logic                in_zero;
    logic                in_one;
    logic                in_special;
    logic                over_tol;
    logic                at_cap;
    logic                out_free;
    logic [ROOT_W-1:0]   next_sat;
    logic [WORK_W:0]     d_fwd;
    logic [WORK_W:0]     sum;
    t_work               div_src;

    assign in_val     = s_tdata[VALUE_W-1:0];
    assign s_tready   = (r_state == S_IDLE);
    assign in_acc     = s_tvalid && s_tready;
    assign in_neg     = in_val[VALUE_W-1];
    assign in_zero    = (in_val == '0);
    assign in_one     = (in_val == (VALUE_W'(1) << FRAC_BITS));
    assign in_special = in_neg || in_zero || in_one;

    assign over_tol = (r_diff > t_work'(r_tol));
    assign at_cap   = (r_steps >= STEP_W'(MAX_ITER));
    assign out_free = !r_m_valid || m_tready;
    assign next_sat = (|r_next[WORK_W-1:ROOT_W]) ? ROOT_MAX : r_next[ROOT_W-1:0];
    assign d_fwd    = {1'b0, r_last} - {1'b0, r_next};
    assign sum      = {1'b0, r_last} + {1'b0, div_rsp.quotient};

    // start a division on a regular operand, or for the next step
    always_comb begin
        div_src          = (r_state == S_IDLE) ? t_work'(in_val) : r_next;
        div_req.start    = (in_acc && !in_special) ||
                           ((r_state == S_CHECK) && over_tol && !at_cap);
        div_req.dividend = (r_state == S_IDLE) ? (t_work'(in_val) << FRAC_BITS) : r_scaled;
        div_req.divisor  = (div_src == '0) ? t_work'(1) : div_src;
    end

    nsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            // load a finished result, or drop the one just taken
            if ((r_state == S_DONE) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= in_special ? S_DONE : S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM:   r_state <= S_DIFF;
                S_DIFF:  r_state <= S_CHECK;
                S_CHECK: r_state <= (over_tol && !at_cap) ? S_DIV : S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_scaled <= t_work'(in_val) << FRAC_BITS;
                    r_last   <= t_work'(in_val);
                    r_steps  <= STEP_W'(1);
                    r_inv    <= in_neg;
                    r_cap    <= 1'b0;
                    r_root   <= (in_one && !in_neg) ? (ROOT_W'(1) << FRAC_BITS) : '0;
                end
            end
            S_SUM:  r_next <= sum[WORK_W:1];
            S_DIFF: r_diff <= d_fwd[WORK_W] ? (r_next - r_last) : d_fwd[WORK_W-1:0];
            S_CHECK: begin
                if (over_tol && !at_cap) begin
                    r_last  <= r_next;
                    r_steps <= r_steps + STEP_W'(1);
                end else begin
                    r_root <= next_sat;
                    r_cap  <= over_tol;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_m_root <= r_root;
                    r_m_inv  <= r_inv;
                    r_m_cap  <= r_cap;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_root;
    assign m_tuser  = {r_m_cap, r_m_inv};

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RST;
        end else if (psel && penable && pwrite && (paddr == ADDR_TOL)) begin
            r_tol <= pwdata[TOL_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_TOL) ? APB_DW'(r_tol) : '0;
    assign pready = 1'b1;

endmodule

`default_nettype wire

### sv/nsr_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on nsr_pkg for widths and the request/response structs.
`default_nettype none

module nsr_div import nsr_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [WORK_W:0]   r_rem;
    t_work             r_quo;
    t_work             r_div;

    logic [WORK_W:0]   rem_sh;
    logic [WORK_W:0]   rem_sub;
    logic              ge;
    logic [WORK_W:0]   n_rem;
    t_work             n_quo;

    always_comb begin
        rem_sh  = {r_rem[WORK_W-1:0], r_quo[WORK_W-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        ge      = (rem_sh >= {1'b0, r_div});
        n_rem   = ge ? rem_sub : rem_sh;
        n_quo   = {r_quo[WORK_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(WORK_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift dividend bits out at the top, quotient bits in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

### sv/nsr_checker.sv
// Port-level checks for newton_square_root_core, bound to the top level.
// Imports nsr_pkg but uses none of its items.
`default_nettype none

module nsr_checker import nsr_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        pready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // negative operand gives a zero root and is never capped
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("invalid result with nonzero root or cap flag");

    // an accepted item keeps the core busy in the cycle after it is taken
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

endmodule

bind newton_square_root_core nsr_checker u_nsr_checker (.*);

`default_nettype wire
